### rtl/char_lcd_command_sequencer_macros.svh
// Assertion macros used by the checker file of the LCD command sequencer.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_MACROS_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define LCDSEQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lcdseq assertion failed");

// A stalled item keeps its payload until it is taken.
`define LCDSEQ_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> (vld && $stable(sig))) \
		else $error("lcdseq stalled item changed");

`endif

### rtl/lcdseq_pkg.sv
package lcdseq_pkg;

	// Host request codes
	typedef enum logic [2:0] {
		FN_INIT       = 3'd0,
		FN_CLEAR      = 3'd1,
		FN_SET_CURSOR = 3'd2,
		FN_PUT_CHAR   = 3'd3,
		FN_WRITE_NEXT = 3'd4,
		FN_CLEAR_ROW  = 3'd5
	} func_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ROW_COUNT     = 2'd0,
		REG_COLUMN_COUNT  = 2'd1,
		REG_BUS_EIGHT_BIT = 2'd2
	} cfg_reg_t;

	// Jobs handed from the front end to the back end
	typedef enum logic [2:0] {
		JOB_REJECT,
		JOB_CLEAR,
		JOB_CURSOR,
		JOB_PUT,
		JOB_NEXT,
		JOB_ROW,
		JOB_INIT4,
		JOB_INIT8
	} job_kind_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam logic [7:0]  ADDR_ROW_EVEN = 8'h80;
	localparam logic [7:0]  ADDR_ROW_ODD  = 8'hc0;
	localparam logic [7:0]  CMD_WAKEUP    = 8'h30;
	localparam logic [7:0]  CMD_FUNC_SET  = 8'h20 | 8'h08;
	localparam logic [7:0]  CMD_DISPLAY   = 8'h08 | 8'h04;
	localparam logic [7:0]  CMD_CLEAR     = 8'h01;
	localparam logic [7:0]  CMD_ENTRY     = 8'h04 | 8'h02;
	localparam logic [7:0]  NIB_WAKEUP    = 8'h03;
	localparam logic [7:0]  NIB_FOUR_BIT  = 8'h02;
	localparam logic [7:0]  CHAR_SPACE    = 8'h20;
	localparam logic [14:0] PRE_CMD       = 15'd5;
	localparam logic [14:0] PRE_WAKE0     = 15'd20000;
	localparam logic [14:0] PRE_WAKE1     = 15'd10000;
	localparam logic [14:0] PRE_WAKE2     = 15'd1000;
	localparam logic [10:0] POST_CLEAR    = 11'd2000;

	typedef struct packed {
		logic [2:0] row_count;
		logic [5:0] column_count;
		logic       bus_eight_bit;
	} cfg_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] addr;
		logic [7:0] ch;
		logic [5:0] cols;
	} job_t;

	typedef struct packed {
		logic        rejected;
		logic        reg_select;
		logic [7:0]  bus_value;
		logic        nibble_only;
		logic [14:0] pre_wait_us;
		logic [10:0] post_wait_us;
		logic        last;
	} item_t;

	// Power-up sequence, one item per step
	function automatic item_t init_item(input logic eight, input logic [2:0] idx);
		item_t it;
		it = '0;
		it.pre_wait_us = PRE_CMD;
		case (idx)
			3'd0: begin
				it.pre_wait_us = PRE_WAKE0;
			end
			3'd1: begin
				it.pre_wait_us = PRE_WAKE1;
			end
			3'd2: begin
				it.pre_wait_us = PRE_WAKE2;
			end
			3'd3: begin
				it.pre_wait_us = '0;
				it.bus_value   = NIB_FOUR_BIT;
				it.nibble_only = 1'b1;
			end
			3'd4: it.bus_value = CMD_FUNC_SET;
			3'd5: it.bus_value = CMD_DISPLAY;
			3'd6: begin
				it.bus_value    = CMD_CLEAR;
				it.post_wait_us = POST_CLEAR;
			end
			default: it.bus_value = CMD_ENTRY;
		endcase
		if (idx < 3'd3) begin
			it.bus_value   = eight ? CMD_WAKEUP : NIB_WAKEUP;
			it.nibble_only = !eight;
		end
		it.last = eight ? (idx == 3'd2) : (idx == 3'd7);
		return it;
	endfunction

endpackage

### rtl/lcdseq_front.sv
// Front end: decodes host requests into jobs and tracks the write-next column
module lcdseq_front #(
	parameter int MAX_COLUMNS = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lcdseq_pkg::cfg_t    cfg,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [2:0]          func,
	input  logic [1:0]          row_sel,
	input  logic [5:0]          col_sel,
	input  logic [7:0]          char_code,
	output logic                job_push,
	output lcdseq_pkg::job_t    job,
	input  logic                queue_full
);

	localparam logic [5:0] COLS_LIMIT = 6'(MAX_COLUMNS);
	localparam logic [7:0] ADDR_EVEN  = lcdseq_pkg::ADDR_ROW_EVEN;
	localparam logic [7:0] ADDR_ODD   = lcdseq_pkg::ADDR_ROW_ODD;

	logic [5:0] next_col_q;
	logic [5:0] next_col_d;
	logic [5:0] cols;
	logic       one_row;
	logic       pos_ok;
	logic       row_ok;
	logic [7:0] pos_addr_v;
	logic [7:0] row_addr_v;

	// Display address of a row and column
	function automatic logic [7:0] pos_addr(input logic [1:0] row, input logic [5:0] col,
			input logic [5:0] ncols, input logic single);
		logic [5:0] half;
		logic [7:0] a;
		half = ncols >> 1;
		case (row)
			2'd0: begin
				if (single && col >= half)
					a = ADDR_ODD + {2'b00, col} - {2'b00, half};
				else
					a = ADDR_EVEN + {2'b00, col};
			end
			2'd1: a = ADDR_ODD + {2'b00, col};
			2'd2: a = ADDR_EVEN + {2'b00, ncols} + {2'b00, col};
			default: a = ADDR_ODD + {2'b00, ncols} + {2'b00, col};
		endcase
		return a;
	endfunction

	// Columns in use and position checks
	assign cols       = (cfg.column_count > COLS_LIMIT) ? COLS_LIMIT : cfg.column_count;
	assign one_row    = (cfg.row_count == 3'd1);
	assign row_ok     = ({1'b0, row_sel} < cfg.row_count) && (cols != '0);
	assign pos_ok     = ({1'b0, row_sel} < cfg.row_count) && (col_sel < cols);
	assign pos_addr_v = pos_addr(row_sel, col_sel, cols, one_row);
	assign row_addr_v = pos_addr(row_sel, 6'd0, cols, one_row);

	assign req_ready = !queue_full;
	assign job_push  = req_valid && req_ready;

	// Request decode
	always_comb begin
		job        = '0;
		job.kind   = lcdseq_pkg::JOB_REJECT;
		job.ch     = char_code;
		job.cols   = cols;
		next_col_d = next_col_q;
		unique case (lcdseq_pkg::func_t'(func))
			lcdseq_pkg::FN_INIT: begin
				job.kind   = cfg.bus_eight_bit ? lcdseq_pkg::JOB_INIT8 : lcdseq_pkg::JOB_INIT4;
				next_col_d = '0;
			end
			lcdseq_pkg::FN_CLEAR: begin
				job.kind   = lcdseq_pkg::JOB_CLEAR;
				next_col_d = '0;
			end
			lcdseq_pkg::FN_SET_CURSOR: begin
				if (pos_ok) begin
					job.kind   = lcdseq_pkg::JOB_CURSOR;
					job.addr   = pos_addr_v;
					next_col_d = col_sel;
				end
			end
			lcdseq_pkg::FN_PUT_CHAR: begin
				if (pos_ok) begin
					job.kind   = lcdseq_pkg::JOB_PUT;
					job.addr   = pos_addr_v;
					next_col_d = col_sel + 6'd1;
				end
			end
			lcdseq_pkg::FN_WRITE_NEXT: begin
				if (next_col_q < cols) begin
					job.kind   = lcdseq_pkg::JOB_NEXT;
					next_col_d = next_col_q + 6'd1;
				end
			end
			lcdseq_pkg::FN_CLEAR_ROW: begin
				if (row_ok) begin
					job.kind   = lcdseq_pkg::JOB_ROW;
					job.addr   = row_addr_v;
					next_col_d = '0;
				end
			end
			default: begin
				job.kind = lcdseq_pkg::JOB_REJECT;
			end
		endcase
	end

	// Write-next column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_col_q <= '0;
		end else if (job_push) begin
			next_col_q <= next_col_d;
		end
	end

endmodule

### rtl/lcdseq_queue.sv
// Short job queue between front and back end
module lcdseq_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lcdseq_pkg::job_t din,
	output logic             full,
	input  logic             pop,
	output lcdseq_pkg::job_t dout,
	output logic             valid
);

	lcdseq_pkg::job_t                  mem_q [lcdseq_pkg::QUEUE_DEPTH];
	logic [lcdseq_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [lcdseq_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [lcdseq_pkg::QUEUE_AW:0]     count_q;
	logic                              do_push;
	logic                              do_pop;

	assign full    = (count_q == (lcdseq_pkg::QUEUE_AW + 1)'(lcdseq_pkg::QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!do_push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/lcdseq_back.sv
// Back end: expands each job into its run of bus transfer items
module lcdseq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  lcdseq_pkg::job_t  job,
	output logic              job_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output lcdseq_pkg::item_t out_item
);

	lcdseq_pkg::job_t  cur_q;
	logic              cur_v_q;
	logic [5:0]        step_q;
	lcdseq_pkg::item_t item;
	lcdseq_pkg::item_t out_q;
	logic              out_v_q;
	logic              adv;
	logic [5:0]        row_end;

	assign row_end  = cur_q.cols + 6'd1;
	assign adv      = cur_v_q && (!out_v_q || out_ready);
	assign job_pop  = job_valid && (!cur_v_q || (adv && item.last));
	assign out_valid = out_v_q;
	assign out_item  = out_q;

	// Item for the current step
	always_comb begin
		item             = '0;
		item.pre_wait_us = lcdseq_pkg::PRE_CMD;
		unique case (cur_q.kind)
			lcdseq_pkg::JOB_REJECT: begin
				item.rejected    = 1'b1;
				item.pre_wait_us = '0;
				item.last        = 1'b1;
			end
			lcdseq_pkg::JOB_CLEAR: begin
				item.bus_value    = lcdseq_pkg::CMD_CLEAR;
				item.post_wait_us = lcdseq_pkg::POST_CLEAR;
				item.last         = 1'b1;
			end
			lcdseq_pkg::JOB_CURSOR: begin
				item.bus_value = cur_q.addr;
				item.last      = 1'b1;
			end
			lcdseq_pkg::JOB_PUT: begin
				if (step_q == '0) begin
					item.bus_value = cur_q.addr;
				end else begin
					item.reg_select = 1'b1;
					item.bus_value  = cur_q.ch;
					item.last       = 1'b1;
				end
			end
			lcdseq_pkg::JOB_NEXT: begin
				item.reg_select = 1'b1;
				item.bus_value  = cur_q.ch;
				item.last       = 1'b1;
			end
			lcdseq_pkg::JOB_ROW: begin
				if (step_q == '0 || step_q == row_end) begin
					item.bus_value = cur_q.addr;
				end else begin
					item.reg_select = 1'b1;
					item.bus_value  = lcdseq_pkg::CHAR_SPACE;
				end
				item.last = (step_q == row_end);
			end
			lcdseq_pkg::JOB_INIT4: item = lcdseq_pkg::init_item(1'b0, step_q[2:0]);
			default:               item = lcdseq_pkg::init_item(1'b1, step_q[2:0]);
		endcase
	end

	// Current job and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			step_q  <= '0;
		end else if (job_pop) begin
			cur_v_q <= 1'b1;
			step_q  <= '0;
		end else if (adv && item.last) begin
			cur_v_q <= 1'b0;
		end else if (adv) begin
			step_q <= step_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= item;
		end
	end

endmodule

### rtl/char_lcd_command_sequencer.sv
// Character LCD command sequencer. The front end takes one host request per
// cycle while its four-entry job queue has room; the back end then emits one
// bus transfer item per cycle whenever the output register is free or being
// taken. Each request expands into a run of items: one for clear, set cursor,
// write next and a refusal, two for put char, three or eight for init (8-bit
// or 4-bit bus) and the column count plus two for clear row. The back end's
// single item-per-cycle output sets the sustained rate.
module char_lcd_command_sequencer #(
	parameter int MAX_COLUMNS = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // row_sel[1:0], col_sel[7:2], char_code[15:8]
	input  logic [2:0]  s_tuser,  // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // bus_value[7:0], pre_wait_us[22:8], post_wait_us[33:23]
	output logic [2:0]  m_tuser,  // rejected[0], reg_select[1], nibble_only[2]
	output logic        m_tlast
);

	lcdseq_pkg::cfg_t  cfg_q;
	lcdseq_pkg::job_t  push_job;
	lcdseq_pkg::job_t  head_job;
	lcdseq_pkg::item_t out_item;
	logic              job_push;
	logic              job_pop;
	logic              queue_full;
	logic              queue_valid;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count     <= 3'd2;
			cfg_q.column_count  <= 6'd16;
			cfg_q.bus_eight_bit <= 1'b0;
		end else if (cfg_we) begin
			unique case (lcdseq_pkg::cfg_reg_t'(cfg_index))
				lcdseq_pkg::REG_ROW_COUNT:     cfg_q.row_count     <= cfg_wdata[2:0];
				lcdseq_pkg::REG_COLUMN_COUNT:  cfg_q.column_count  <= cfg_wdata;
				lcdseq_pkg::REG_BUS_EIGHT_BIT: cfg_q.bus_eight_bit <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	lcdseq_front #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.func       (s_tuser),
		.row_sel    (s_tdata[1:0]),
		.col_sel    (s_tdata[7:2]),
		.char_code  (s_tdata[15:8]),
		.job_push   (job_push),
		.job        (push_job),
		.queue_full (queue_full)
	);

	lcdseq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (push_job),
		.full   (queue_full),
		.pop    (job_pop),
		.dout   (head_job),
		.valid  (queue_valid)
	);

	lcdseq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (queue_valid),
		.job       (head_job),
		.job_pop   (job_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	// Output packing
	assign m_tdata = {6'b000000, out_item.post_wait_us, out_item.pre_wait_us,
			out_item.bus_value};
	assign m_tuser = {out_item.nibble_only, out_item.reg_select, out_item.rejected};
	assign m_tlast = out_item.last;

endmodule

### rtl/lcdseq_checker.sv
`include "char_lcd_command_sequencer_macros.svh"

// Port-level checks on the sequencer's result stream
module lcdseq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// A refusal is a run of its own
	`LCDSEQ_ASSERT(a_reject_last, clk, arst_n, (m_tvalid && m_tuser[0]) |-> m_tlast)
	// A refusal carries no transfer
	`LCDSEQ_ASSERT(a_reject_empty, clk, arst_n, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && m_tuser[2:1] == 2'b00))
	// Nibble-only strobes go to the instruction register
	`LCDSEQ_ASSERT(a_nibble_instr, clk, arst_n, (m_tvalid && m_tuser[2]) |-> (!m_tuser[1] && !m_tuser[0]))
	// A stalled item holds
	`LCDSEQ_ASSERT_HOLD(a_out_hold, clk, arst_n, m_tvalid, m_tready, {m_tdata, m_tuser, m_tlast})

endmodule

bind char_lcd_command_sequencer lcdseq_checker u_lcdseq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
